[hw/rtl/cctm_pkg.sv]
// Shared types and constants for the conjugate-transpose matrix product block.
// Holds request and register codes, sequencer states and the MAC control bundle.
// No dependencies.
`timescale 1ns / 1ps

package cctm_pkg;

  localparam int unsigned RESULT_WIDTH = 41;
  localparam int unsigned ROWS_WIDTH   = 7;
  localparam int unsigned COLS_WIDTH   = 9;
  localparam int unsigned CFG_WIDTH    = 9;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned VALUE_WIDTH  = 16;

  localparam logic [ROWS_WIDTH-1:0] ROWS_A_RESET    = 7'd64;
  localparam logic [ROWS_WIDTH-1:0] ROWS_B_RESET    = 7'd64;
  localparam logic [COLS_WIDTH-1:0] COL_COUNT_RESET = 9'd256;

  typedef enum logic [1:0] {
    REQ_LOAD_A  = 2'd0,
    REQ_LOAD_B  = 2'd1,
    REQ_COMPUTE = 2'd2
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_A    = 2'd0,
    REG_ROWS_B    = 2'd1,
    REG_COL_COUNT = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SEQ_IDLE  = 2'd0,
    SEQ_RUN   = 2'd1,
    SEQ_DRAIN = 2'd2
  } seq_state_e;

  // Tags that travel with each element pair through the MAC
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

[hw/rtl/cctm_store.sv]
// Simple dual-port sample memory: one write port, one registered read port.
// Depends on nothing; instantiated once for A and once for B.
`timescale 1ns / 1ps

module cctm_store #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = 14,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/cctm_mac.sv]
// Shared complex multiply-accumulate unit: product stage, then wide accumulate.
// Depends on cctm_pkg for the control bundle and result width.
`timescale 1ns / 1ps

module cctm_mac #(
  parameter int unsigned SW = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  cctm_pkg::mac_ctl_t                     ctl_i,
  input  logic signed [SW-1:0]                   a_re_i,
  input  logic signed [SW-1:0]                   a_im_i,
  input  logic signed [SW-1:0]                   b_re_i,
  input  logic signed [SW-1:0]                   b_im_i,
  output logic [cctm_pkg::RESULT_WIDTH-1:0]      acc_re_o,
  output logic [cctm_pkg::RESULT_WIDTH-1:0]      acc_im_o,
  output logic                                   done_o
);

  localparam int unsigned PW   = 2 * SW;
  localparam int unsigned SUMW = PW + 1;
  localparam int unsigned RW   = cctm_pkg::RESULT_WIDTH;
  localparam int unsigned EXTW = (SUMW > RW) ? SUMW : RW;

  cctm_pkg::mac_ctl_t     ctl_q;
  logic signed [PW-1:0]   p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [SUMW-1:0] sum_re, sum_im;
  logic signed [EXTW-1:0] ext_re, ext_im;
  logic [RW-1:0]          acc_re_q, acc_re_d;
  logic [RW-1:0]          acc_im_q, acc_im_d;
  logic                   done_q;

  // Product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      p_rr_q <= a_re_i * b_re_i;
      p_ii_q <= a_im_i * b_im_i;
      p_ri_q <= a_re_i * b_im_i;
      p_ir_q <= a_im_i * b_re_i;
    end
  end

  // Accumulate stage, wraps modulo the result width
  always_comb begin
    sum_re   = SUMW'(p_rr_q) + SUMW'(p_ii_q);
    sum_im   = SUMW'(p_ri_q) - SUMW'(p_ir_q);
    ext_re   = EXTW'(sum_re);
    ext_im   = EXTW'(sum_im);
    acc_re_d = (ctl_q.first ? '0 : acc_re_q) + ext_re[RW-1:0];
    acc_im_d = (ctl_q.first ? '0 : acc_im_q) + ext_im[RW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_q.valid) begin
      acc_re_q <= acc_re_d;
      acc_im_q <= acc_im_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_q.valid & ctl_q.last;
    end
  end

  assign acc_re_o = acc_re_q;
  assign acc_im_o = acc_im_q;
  assign done_o   = done_q;

endmodule

[hw/rtl/cctm_ctrl.sv]
// Sequencer that walks one row pair through the memories, one column a cycle.
// Depends on cctm_pkg for states and the MAC control bundle.
`timescale 1ns / 1ps

module cctm_ctrl #(
  parameter int unsigned AW = 14
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                launch_i,
  input  logic [AW-1:0]                       a_base_i,
  input  logic [AW-1:0]                       b_base_i,
  input  logic [cctm_pkg::COLS_WIDTH-1:0]     nc_i,
  input  logic                                mac_done_i,
  output logic                                busy_o,
  output logic                                rd_en_o,
  output logic [AW-1:0]                       a_addr_o,
  output logic [AW-1:0]                       b_addr_o,
  output cctm_pkg::mac_ctl_t                  mac_ctl_o
);

  localparam int unsigned CW = cctm_pkg::COLS_WIDTH;

  cctm_pkg::seq_state_e state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        nc_q, nc_d;
  logic [AW-1:0]        a_addr_q, a_addr_d;
  logic [AW-1:0]        b_addr_q, b_addr_d;
  cctm_pkg::mac_ctl_t   tag_q, tag_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cctm_pkg::SEQ_IDLE;
      tag_q   <= '0;
    end else begin
      state_q <= state_d;
      tag_q   <= tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    nc_q     <= nc_d;
    a_addr_q <= a_addr_d;
    b_addr_q <= b_addr_d;
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    nc_d     = nc_q;
    a_addr_d = a_addr_q;
    b_addr_d = b_addr_q;
    tag_d    = '0;
    rd_en_o  = 1'b0;
    case (state_q)
      cctm_pkg::SEQ_IDLE: begin
        if (launch_i) begin
          cnt_d    = '0;
          nc_d     = nc_i;
          a_addr_d = a_base_i;
          b_addr_d = b_base_i;
          state_d  = cctm_pkg::SEQ_RUN;
        end
      end
      cctm_pkg::SEQ_RUN: begin
        // issue one element pair read and advance
        rd_en_o     = 1'b1;
        tag_d.valid = 1'b1;
        tag_d.first = (cnt_q == '0);
        tag_d.last  = (cnt_q == nc_q - CW'(1));
        cnt_d       = cnt_q + CW'(1);
        a_addr_d    = a_addr_q + AW'(1);
        b_addr_d    = b_addr_q + AW'(1);
        if (tag_d.last) begin
          state_d = cctm_pkg::SEQ_DRAIN;
        end
      end
      cctm_pkg::SEQ_DRAIN: begin
        if (mac_done_i) begin
          state_d = cctm_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_d = cctm_pkg::SEQ_IDLE;
      end
    endcase
  end

  assign busy_o    = (state_q != cctm_pkg::SEQ_IDLE);
  assign a_addr_o  = a_addr_q;
  assign b_addr_o  = b_addr_q;
  assign mac_ctl_o = tag_q;

endmodule

[hw/rtl/complex_conj_transpose_matmul.sv]
// Top level of the conjugate-transpose matrix product block, C = A^H * B.
// Depends on cctm_pkg, cctm_store, cctm_mac and cctm_ctrl.
`timescale 1ns / 1ps

// A load transaction (req_type 0 or 1) writes one complex sample of A or B in
// the cycle it is accepted, and start may be held high for the next load right
// away. A compute transaction (req_type 2) with rows in range and an effective
// column count nc > 0 keeps busy high while the single multiply-accumulate unit
// takes one element pair per cycle from the read ports of the two memories:
// the last pair passes the read register, the product stage, the accumulator
// and the done register before result_valid_o is set, and busy is already low
// then, so the next transaction can be taken at the edge ending that cycle.
// A compute with a row out of range, or with nc = 0, answers in the cycle
// right after acceptance without raising busy. Each result is on the
// ports for exactly one cycle; the receiver cannot stall it, so sample
// result_valid_o on every clock. The memories are not cleared: read only
// entries that have been loaded. Request code 3 is dropped.

module complex_conj_transpose_matmul #(
  parameter int unsigned MAX_ROWS     = 64,
  parameter int unsigned MAX_COLS     = 256,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // command channel
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             req_type_i,
  input  logic [5:0]                             row_index_i,
  input  logic [7:0]                             col_index_i,
  input  logic [5:0]                             b_row_index_i,
  input  logic signed [cctm_pkg::VALUE_WIDTH-1:0] value_re_i,
  input  logic signed [cctm_pkg::VALUE_WIDTH-1:0] value_im_i,
  // result channel
  output logic                                   result_valid_o,
  output logic signed [cctm_pkg::RESULT_WIDTH-1:0] result_re_o,
  output logic signed [cctm_pkg::RESULT_WIDTH-1:0] result_im_o,
  output logic                                   index_error_o,
  // configuration write port
  input  logic                                   cfg_we_i,
  input  logic [cctm_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [cctm_pkg::CFG_WIDTH-1:0]         cfg_wdata_i
);

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned DW    = 2 * SW;
  localparam int unsigned RW    = cctm_pkg::RESULT_WIDTH;
  localparam int unsigned CW    = cctm_pkg::COLS_WIDTH;

  // Configuration registers
  logic [cctm_pkg::ROWS_WIDTH-1:0] rows_a_q, rows_b_q;
  logic [CW-1:0]                   col_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= cctm_pkg::ROWS_A_RESET;
      rows_b_q    <= cctm_pkg::ROWS_B_RESET;
      col_count_q <= cctm_pkg::COL_COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cctm_pkg::cfg_reg_e'(cfg_index_i))
        cctm_pkg::REG_ROWS_A:    rows_a_q    <= cfg_wdata_i[cctm_pkg::ROWS_WIDTH-1:0];
        cctm_pkg::REG_ROWS_B:    rows_b_q    <= cfg_wdata_i[cctm_pkg::ROWS_WIDTH-1:0];
        cctm_pkg::REG_COL_COUNT: col_count_q <= cfg_wdata_i[CW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Decode of the accepted transaction
  logic          accept;
  logic          is_load_a, is_load_b, is_compute;
  logic          load_ok, rows_ok, nc_zero, launch;
  logic          err_evt, zero_evt;
  logic [31:0]   nc_full;
  logic [CW-1:0] nc;
  logic [31:0]   load_addr_full, a_base_full, b_base_full;
  logic [31:0]   re_ext, im_ext;
  logic [DW-1:0] wdata;

  assign accept = start & ~busy;

  always_comb begin
    is_load_a  = 1'b0;
    is_load_b  = 1'b0;
    is_compute = 1'b0;
    case (cctm_pkg::req_type_e'(req_type_i))
      cctm_pkg::REQ_LOAD_A:  is_load_a  = 1'b1;
      cctm_pkg::REQ_LOAD_B:  is_load_b  = 1'b1;
      cctm_pkg::REQ_COMPUTE: is_compute = 1'b1;
      default: begin
      end
    endcase
  end

  always_comb begin
    // loads outside the physical memory are dropped
    load_ok = (32'(row_index_i) < 32'(MAX_ROWS)) && (32'(col_index_i) < 32'(MAX_COLS));
    // effective row counts are the configured ones capped at the memory size
    rows_ok = (32'(row_index_i) < 32'(MAX_ROWS)) && (row_index_i < 6'(rows_a_q) ||
               rows_a_q[6]) &&
              (32'(b_row_index_i) < 32'(MAX_ROWS)) && (b_row_index_i < 6'(rows_b_q) ||
               rows_b_q[6]);
    nc_full = (32'(col_count_q) > 32'(MAX_COLS)) ? 32'(MAX_COLS) : 32'(col_count_q);
    nc      = nc_full[CW-1:0];
    nc_zero = (nc == '0);

    load_addr_full = 32'(row_index_i) * 32'(MAX_COLS) + 32'(col_index_i);
    a_base_full    = 32'(row_index_i) * 32'(MAX_COLS);
    b_base_full    = 32'(b_row_index_i) * 32'(MAX_COLS);

    // keep the low sample bits of each loaded part
    re_ext = {16'b0, value_re_i};
    im_ext = {16'b0, value_im_i};
    wdata  = {re_ext[SW-1:0], im_ext[SW-1:0]};

    err_evt  = accept & is_compute & ~rows_ok;
    zero_evt = accept & is_compute & rows_ok & nc_zero;
    launch   = accept & is_compute & rows_ok & ~nc_zero;
  end

  // Sequencer
  logic               rd_en;
  logic [AW-1:0]      a_raddr, b_raddr;
  cctm_pkg::mac_ctl_t mac_ctl;
  logic               mac_done;

  cctm_ctrl #(
    .AW (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .launch_i   (launch),
    .a_base_i   (a_base_full[AW-1:0]),
    .b_base_i   (b_base_full[AW-1:0]),
    .nc_i       (nc),
    .mac_done_i (mac_done),
    .busy_o     (busy),
    .rd_en_o    (rd_en),
    .a_addr_o   (a_raddr),
    .b_addr_o   (b_raddr),
    .mac_ctl_o  (mac_ctl)
  );

  // Sample memories
  logic [DW-1:0] a_rdata, b_rdata;

  cctm_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (accept & is_load_a & load_ok),
    .waddr_i (load_addr_full[AW-1:0]),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  cctm_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (accept & is_load_b & load_ok),
    .waddr_i (load_addr_full[AW-1:0]),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // Multiply-accumulate unit, fed straight from the registered read data
  logic [RW-1:0] acc_re, acc_im;

  cctm_mac #(
    .SW (SW)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mac_ctl),
    .a_re_i   ($signed(a_rdata[DW-1:SW])),
    .a_im_i   ($signed(a_rdata[SW-1:0])),
    .b_re_i   ($signed(b_rdata[DW-1:SW])),
    .b_im_i   ($signed(b_rdata[SW-1:0])),
    .acc_re_o (acc_re),
    .acc_im_o (acc_im),
    .done_o   (mac_done)
  );

  // Result register: one-cycle strobe, payload held without reset
  logic          res_valid_q;
  logic [RW-1:0] res_re_q, res_im_q;
  logic          res_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= err_evt | zero_evt | mac_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (err_evt | zero_evt | mac_done) begin
      res_re_q  <= mac_done ? acc_re : '0;
      res_im_q  <= mac_done ? acc_im : '0;
      res_err_q <= err_evt;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_re_o    = $signed(res_re_q);
  assign result_im_o    = $signed(res_im_q);
  assign index_error_o  = res_err_q;

  // Checks
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && index_error_o |-> result_re_o == '0 && result_im_o == '0)
    else $error("index error result carries a non-zero sum");

  a_launch_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch |=> busy)
    else $error("compute launched but sequencer not busy");

  a_mac_in_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_ctl.valid |-> busy)
    else $error("element pair in flight while sequencer idle");

  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> busy)
    else $error("accumulator finished outside a compute");

endmodule

[tb/cctm_product_check.sv]
// Result checker for the conjugate-transpose matrix product block.
// Mirrors both element memories and the registers, predicts every C entry.
// Depends on cctm_pkg.
`timescale 1ns / 1ps

module cctm_product_check
  import cctm_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic [1:0]                     req_type_i,
  input  logic [5:0]                     row_index_i,
  input  logic [7:0]                     col_index_i,
  input  logic [5:0]                     b_row_index_i,
  input  logic signed [VALUE_WIDTH-1:0]  value_re_i,
  input  logic signed [VALUE_WIDTH-1:0]  value_im_i,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [CFG_WIDTH-1:0]           cfg_wdata_i,
  input  logic                           result_valid_i,
  input  logic signed [RESULT_WIDTH-1:0] result_re_i,
  input  logic signed [RESULT_WIDTH-1:0] result_im_i,
  input  logic                           index_error_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o,
  output int unsigned                    products_o,
  output int unsigned                    index_errors_o
);

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;

  typedef struct {
    logic signed [RESULT_WIDTH-1:0] re;
    logic signed [RESULT_WIDTH-1:0] im;
    logic                           err;
  } c_entry_t;

  logic signed [VALUE_WIDTH-1:0] a_re_mem [DEPTH];
  logic signed [VALUE_WIDTH-1:0] a_im_mem [DEPTH];
  logic signed [VALUE_WIDTH-1:0] b_re_mem [DEPTH];
  logic signed [VALUE_WIDTH-1:0] b_im_mem [DEPTH];

  logic [ROWS_WIDTH-1:0] rows_a_q;
  logic [ROWS_WIDTH-1:0] rows_b_q;
  logic [COLS_WIDTH-1:0] col_count_q;

  c_entry_t    awaited_c[$];
  c_entry_t    oldest_c;
  int unsigned elem_addr;
  int unsigned bad_fields;

  // Exact sum of conj(A[arow][k]) * B[brow][k], wrapped to the result width
  function automatic c_entry_t c_entry_of(input int unsigned arow, input int unsigned brow);
    c_entry_t    e;
    int unsigned ra;
    int unsigned rb;
    int unsigned nc;
    int unsigned abase;
    int unsigned bbase;
    longint      sum_re;
    longint      sum_im;
    ra = (rows_a_q > MAX_ROWS) ? MAX_ROWS : rows_a_q;
    rb = (rows_b_q > MAX_ROWS) ? MAX_ROWS : rows_b_q;
    nc = (col_count_q > MAX_COLS) ? MAX_COLS : col_count_q;
    e.re  = '0;
    e.im  = '0;
    e.err = 1'b1;
    if (arow >= ra || brow >= rb) return e;
    sum_re = 0;
    sum_im = 0;
    abase  = arow * MAX_COLS;
    bbase  = brow * MAX_COLS;
    for (int unsigned k = 0; k < nc; k++) begin
      sum_re += longint'(a_re_mem[abase+k]) * longint'(b_re_mem[bbase+k])
              + longint'(a_im_mem[abase+k]) * longint'(b_im_mem[bbase+k]);
      sum_im += longint'(a_re_mem[abase+k]) * longint'(b_im_mem[bbase+k])
              - longint'(a_im_mem[abase+k]) * longint'(b_re_mem[bbase+k]);
    end
    e.re  = sum_re[RESULT_WIDTH-1:0];
    e.im  = sum_im[RESULT_WIDTH-1:0];
    e.err = 1'b0;
    return e;
  endfunction

  function automatic int unsigned differs(input string name,
                                          input logic signed [RESULT_WIDTH-1:0] want,
                                          input logic signed [RESULT_WIDTH-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q       <= ROWS_A_RESET;
      rows_b_q       <= ROWS_B_RESET;
      col_count_q    <= COL_COUNT_RESET;
      awaited_c.delete();
      fail_count_o   <= 0;
      pending_o      <= 0;
      products_o     <= 0;
      index_errors_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ROWS_A:    rows_a_q    <= cfg_wdata_i[ROWS_WIDTH-1:0];
          REG_ROWS_B:    rows_b_q    <= cfg_wdata_i[ROWS_WIDTH-1:0];
          REG_COL_COUNT: col_count_q <= cfg_wdata_i[COLS_WIDTH-1:0];
          default: ;
        endcase
      end

      if (start_i && !busy_i) begin
        elem_addr = row_index_i * MAX_COLS + col_index_i;
        case (req_type_i)
          REQ_LOAD_A: begin
            a_re_mem[elem_addr] = value_re_i;
            a_im_mem[elem_addr] = value_im_i;
          end
          REQ_LOAD_B: begin
            b_re_mem[elem_addr] = value_re_i;
            b_im_mem[elem_addr] = value_im_i;
          end
          REQ_COMPUTE: awaited_c.push_back(c_entry_of(row_index_i, b_row_index_i));
          default: ;
        endcase
      end

      if (result_valid_i) begin
        if (awaited_c.size() == 0) begin
          $error("result with no compute outstanding: re %0d im %0d index_error %0d",
                 result_re_i, result_im_i, index_error_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          oldest_c   = awaited_c.pop_front();
          bad_fields = differs("result_re", oldest_c.re, result_re_i)
                     + differs("result_im", oldest_c.im, result_im_i)
                     + differs("index_error", oldest_c.err, index_error_i);
          if (bad_fields != 0) fail_count_o <= fail_count_o + 1;
          products_o <= products_o + 1;
          if (oldest_c.err) index_errors_o <= index_errors_o + 1;
        end
      end

      pending_o <= awaited_c.size();
    end
  end

endmodule

[tb/complex_conj_transpose_matmul_tb.sv]
// Testbench top for complex_conj_transpose_matmul: reset, register settings,
// directed and random load/compute traffic, verdict. Depends on cctm_pkg and
// cctm_product_check, which predicts and checks every result.
`timescale 1ns / 1ps

module complex_conj_transpose_matmul_tb;
  import cctm_pkg::*;

  localparam int unsigned MAX_ROWS      = 64;
  localparam int unsigned MAX_COLS      = 256;
  localparam int unsigned RESET_CYCLES  = 11;
  // Allow plenty of margin beyond a full-length compute at the end
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned CFG_GUARD     = 8;
  localparam int unsigned CYCLE_LIMIT   = 4_000_000;

  // Codes with no package name: the dropped request and the unused register slot
  localparam logic [1:0]           REQ_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam logic signed [VALUE_WIDTH-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [VALUE_WIDTH-1:0] S_MIN = 16'sh8000;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           start;
  logic                           busy;
  logic [1:0]                     req_type_i;
  logic [5:0]                     row_index_i;
  logic [7:0]                     col_index_i;
  logic [5:0]                     b_row_index_i;
  logic signed [VALUE_WIDTH-1:0]  value_re_i;
  logic signed [VALUE_WIDTH-1:0]  value_im_i;
  logic                           result_valid_o;
  logic signed [RESULT_WIDTH-1:0] result_re_o;
  logic signed [RESULT_WIDTH-1:0] result_im_o;
  logic                           index_error_o;
  logic                           cfg_we_i;
  logic [CFG_IDX_W-1:0]           cfg_index_i;
  logic [CFG_WIDTH-1:0]           cfg_wdata_i;

  int unsigned fail_count;
  int unsigned pending_c;
  int unsigned products_seen;
  int unsigned index_errors_seen;

  // Which elements have been loaded; a compute may only touch these
  bit          a_loaded [MAX_ROWS][MAX_COLS];
  bit          b_loaded [MAX_ROWS][MAX_COLS];
  // Effective register values as the block will use them
  int unsigned eff_ra = MAX_ROWS;
  int unsigned eff_rb = MAX_ROWS;
  int unsigned eff_nc = MAX_COLS;
  int unsigned idle_pct;
  int unsigned transactions_sent;
  int unsigned settings_used;
  int unsigned cycle_count;

  always #1 clk_i = ~clk_i;

  complex_conj_transpose_matmul dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .b_row_index_i  (b_row_index_i),
    .value_re_i     (value_re_i),
    .value_im_i     (value_im_i),
    .result_valid_o (result_valid_o),
    .result_re_o    (result_re_o),
    .result_im_o    (result_im_o),
    .index_error_o  (index_error_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  cctm_product_check #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_product_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .req_type_i     (req_type_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .b_row_index_i  (b_row_index_i),
    .value_re_i     (value_re_i),
    .value_im_i     (value_im_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_i (result_valid_o),
    .result_re_i    (result_re_o),
    .result_im_i    (result_im_o),
    .index_error_i  (index_error_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending_c),
    .products_o     (products_seen),
    .index_errors_o (index_errors_seen)
  );

  // Watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d products outstanding", cycle_count, pending_c);
      $display("** complex_conj_transpose_matmul: FAILED **");
      $finish;
    end
  end

  // Present one transaction and hold it until the block takes it. Inputs and
  // busy are read straight after the edge, i.e. the values the edge saw.
  task automatic send_req(input logic [1:0] kind, input int unsigned row,
                          input int unsigned col, input int unsigned brow,
                          input logic signed [VALUE_WIDTH-1:0] re,
                          input logic signed [VALUE_WIDTH-1:0] im);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start         <= 1'b1;
    req_type_i    <= kind;
    row_index_i   <= 6'(row);
    col_index_i   <= 8'(col);
    b_row_index_i <= 6'(brow);
    value_re_i    <= re;
    value_im_i    <= im;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (kind == REQ_LOAD_A) a_loaded[row][col] = 1'b1;
    if (kind == REQ_LOAD_B) b_loaded[row][col] = 1'b1;
    if (kind != REQ_SPARE) transactions_sent++;
  endtask

  // Harsh values sit on the corners of the sample range
  function automatic logic signed [VALUE_WIDTH-1:0] rand_sample(input bit harsh);
    logic [1:0] pick;
    if (!harsh) return VALUE_WIDTH'($urandom);
    pick = 2'($urandom_range(3));
    case (pick)
      2'd0:    return S_MIN;
      2'd1:    return S_MAX;
      2'd2:    return '0;
      default: return -16'sd1;
    endcase
  endfunction

  task automatic load_elem(input logic [1:0] kind, input int unsigned row,
                           input int unsigned col, input bit harsh);
    send_req(kind, row, col, $urandom_range(MAX_ROWS - 1), rand_sample(harsh),
             rand_sample(harsh));
  endtask

  // col_index and the value fields are don't-care on a compute: randomise them
  task automatic compute_entry(input int unsigned arow, input int unsigned brow);
    send_req(REQ_COMPUTE, arow, $urandom_range(MAX_COLS - 1), brow, VALUE_WIDTH'($urandom),
             VALUE_WIDTH'($urandom));
  endtask

  function automatic bit row_ready(input bit of_b, input int unsigned row,
                                   input int unsigned nc);
    for (int unsigned k = 0; k < nc; k++) begin
      if (of_b ? !b_loaded[row][k] : !a_loaded[row][k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Drop start and hold until every outstanding product has come back
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_c != 0 || busy);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_WIDTH-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Registers change only with the block idle; loads leave no result behind,
  // so add a short guard after the last product before writing
  task automatic set_config(input logic [CFG_WIDTH-1:0] ra_raw, input logic [CFG_WIDTH-1:0] rb_raw,
                            input logic [CFG_WIDTH-1:0] cc_raw, input bit poke_spare);
    wait_drained();
    repeat (CFG_GUARD) @(posedge clk_i);
    if (poke_spare) write_reg(REG_SPARE, '1);
    write_reg(REG_ROWS_A, ra_raw);
    write_reg(REG_ROWS_B, rb_raw);
    write_reg(REG_COL_COUNT, cc_raw);
    cfg_we_i <= 1'b0;
    eff_ra = (ra_raw[ROWS_WIDTH-1:0] > MAX_ROWS) ? MAX_ROWS : ra_raw[ROWS_WIDTH-1:0];
    eff_rb = (rb_raw[ROWS_WIDTH-1:0] > MAX_ROWS) ? MAX_ROWS : rb_raw[ROWS_WIDTH-1:0];
    eff_nc = (cc_raw[COLS_WIDTH-1:0] > MAX_COLS) ? MAX_COLS : cc_raw[COLS_WIDTH-1:0];
    settings_used++;
  endtask

  // Short hand-made part under rows_a 40, rows_b 64, col_count 2
  task automatic run_directed();
    load_elem(REQ_LOAD_A, 0, 0, 1'b0);
    send_req(REQ_LOAD_A, 0, 0, 0, S_MIN, S_MIN);
    send_req(REQ_LOAD_A, 0, 1, 63, S_MAX, S_MAX);
    send_req(REQ_LOAD_B, 63, 0, 0, S_MIN, S_MAX);
    send_req(REQ_LOAD_B, 63, 1, 63, S_MAX, S_MIN);
    send_req(REQ_LOAD_A, 39, 0, 0, 16'sd0, -16'sd1);
    send_req(REQ_LOAD_A, 39, 1, 0, 16'sd1, S_MIN);
    send_req(REQ_LOAD_B, 0, 0, 0, S_MIN, 16'sd0);
    send_req(REQ_LOAD_B, 0, 1, 0, -16'sd1, S_MAX);
    compute_entry(0, 63);
    compute_entry(39, 0);
    compute_entry(0, 0);
    // last row in range, then the first and the highest row out of range
    compute_entry(39, 63);
    compute_entry(40, 0);
    compute_entry(63, 63);
    send_req(REQ_SPARE, 63, 255, 63, S_MAX, S_MIN);
    send_req(REQ_LOAD_A, 63, 255, 63, S_MAX, S_MIN);
    // hold off until everything is back, then a compute straight after a load
    wait_drained();
    send_req(REQ_LOAD_B, 0, 1, 0, S_MIN, S_MIN);
    compute_entry(0, 0);
    compute_entry(39, 63);
  endtask

  // Fill one row pair with a constant and take the product: largest magnitudes
  task automatic fill_const_pair(input int unsigned arow, input int unsigned brow,
                                 input logic signed [VALUE_WIDTH-1:0] fill);
    for (int unsigned k = 0; k < eff_nc; k++) begin
      send_req(REQ_LOAD_A, arow, k, 0, fill, fill);
      send_req(REQ_LOAD_B, brow, k, 0, fill, fill);
    end
    compute_entry(arow, brow);
  endtask

  // Mostly complete sequences (fill a row pair, then compute on it); the rest
  // is abandoned fills, stray loads, dropped codes and one-off computes
  task automatic run_phase(input int unsigned n_items);
    int unsigned first_sent;
    int unsigned dice;
    int unsigned arow;
    int unsigned brow;
    int unsigned alt_a;
    int unsigned alt_b;
    int unsigned n_comp;
    int unsigned fill_len;
    bit          harsh;
    first_sent = transactions_sent;
    while (transactions_sent - first_sent < n_items) begin
      dice  = $urandom_range(99);
      harsh = ($urandom_range(5) == 0);
      if (dice < 65) begin
        if (eff_ra == 0 || eff_rb == 0) begin
          compute_entry($urandom_range(MAX_ROWS - 1), $urandom_range(MAX_ROWS - 1));
        end else begin
          arow = $urandom_range(eff_ra - 1);
          brow = $urandom_range(eff_rb - 1);
          for (int unsigned k = 0; k < eff_nc; k++) begin
            if (!a_loaded[arow][k] || $urandom_range(7) == 0)
              load_elem(REQ_LOAD_A, arow, k, harsh);
            if (!b_loaded[brow][k] || $urandom_range(7) == 0)
              load_elem(REQ_LOAD_B, brow, k, harsh);
          end
          n_comp = $urandom_range(1, 4);
          for (int unsigned j = 0; j < n_comp; j++) begin
            alt_a = $urandom_range(eff_ra - 1);
            alt_b = $urandom_range(eff_rb - 1);
            if (j > 0 && row_ready(1'b0, alt_a, eff_nc) && row_ready(1'b1, alt_b, eff_nc))
              compute_entry(alt_a, alt_b);
            else
              compute_entry(arow, brow);
          end
          if ($urandom_range(29) == 0) wait_drained();
        end
      end else if (dice < 75) begin
        arow     = $urandom_range(MAX_ROWS - 1);
        fill_len = $urandom_range(MAX_COLS / 8);
        for (int unsigned k = 0; k < fill_len; k++)
          load_elem($urandom_range(1) ? REQ_LOAD_B : REQ_LOAD_A, arow, k, harsh);
      end else if (dice < 85) begin
        load_elem($urandom_range(1) ? REQ_LOAD_B : REQ_LOAD_A, $urandom_range(MAX_ROWS - 1),
                  $urandom_range(MAX_COLS - 1), harsh);
      end else if (dice < 90) begin
        send_req(REQ_SPARE, $urandom_range(MAX_ROWS - 1), $urandom_range(MAX_COLS - 1),
                 $urandom_range(MAX_ROWS - 1), VALUE_WIDTH'($urandom), VALUE_WIDTH'($urandom));
      end else begin
        // out-of-range rows always go; in-range ones only onto loaded data
        arow = $urandom_range(MAX_ROWS - 1);
        brow = $urandom_range(MAX_ROWS - 1);
        if (arow >= eff_ra || brow >= eff_rb ||
            (row_ready(1'b0, arow, eff_nc) && row_ready(1'b1, brow, eff_nc)))
          compute_entry(arow, brow);
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    req_type_i    <= REQ_LOAD_A;
    row_index_i   <= '0;
    col_index_i   <= '0;
    b_row_index_i <= '0;
    value_re_i    <= '0;
    value_im_i    <= '0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= REG_ROWS_A;
    cfg_wdata_i   <= '0;
    cycle_count   <= 0;
    idle_pct      = 21;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Light sender gaps first
    set_config(9'd40, 9'd64, 9'd2, 1'b0);
    run_directed();
    set_config(9'd64, 9'd64, 9'd8, 1'b0);
    run_phase(150);
    // no rows of A: every compute flags index_error
    set_config(9'd0, 9'd64, 9'd5, 1'b0);
    run_phase(40);
    // single column, single row of B
    set_config(9'd17, 9'd1, 9'd1, 1'b0);
    run_phase(150);

    // Heavy sender gaps; register values beyond the memory clamp to full size
    idle_pct = 81;
    set_config(9'd127, 9'h1C0, 9'h1FF, 1'b0);
    fill_const_pair(eff_ra - 1, eff_rb - 1, S_MIN);
    // moderate length with uneven row counts
    set_config(9'd30, 9'd45, 9'd24, 1'b0);
    run_phase(100);
    // zero columns: in-range computes give a zero sum
    set_config(9'd64, 9'd64, 9'd0, 1'b0);
    run_phase(30);

    // Back-to-back traffic; the unused register slot is poked once
    idle_pct = 0;
    set_config(9'd50, 9'd33, 9'd37, 1'b0);
    run_phase(250);
    set_config(9'd1, 9'd64, 9'd16, 1'b1);
    run_phase(100);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_c != 0)
      $error("%0d products never arrived", pending_c);

    $display("Sent %0d load/compute transactions over %0d register settings,", transactions_sent,
             settings_used);
    $display("checked %0d products, %0d of them flagged index_error.", products_seen,
             index_errors_seen);
    if (fail_count == 0 && pending_c == 0)
      $display("** complex_conj_transpose_matmul: PASSED **");
    else
      $display("** complex_conj_transpose_matmul: FAILED **");
    $finish;
  end

endmodule
